// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// both macros expect clk and rst_n in scope

// check cons in the same cycle as ante
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// check cons in the cycle after ante
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/nbt_pkg.sv =====
package nbt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int DIST_W   = 8;
    localparam int Q_W      = 16;
    localparam int FEAT_W   = 8;
    localparam int EST_W    = 8;
    localparam int HEARD_W  = 8;
    localparam int SLOT_W   = 6;
    localparam int LIVE_W   = 7;
    localparam int OWN_W    = 2;
    localparam int MARGIN_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd3;

    localparam logic [TIME_W-1:0]   TIMEOUT_RESET = 32'd65535;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET  = 8'd5;

    // 0.9 and 0.1 in units of 1/256
    localparam logic [7:0] AVG_OLD_WEIGHT = 8'd230;
    localparam logic [7:0] AVG_NEW_WEIGHT = 8'd26;
    localparam logic [HEARD_W-1:0] HEARD_MAX = 8'd255;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [Q_W-1:0]     dist_q;
        logic [TIME_W-1:0]  last_heard;
        logic [HEARD_W-1:0] heard;
        logic [FEAT_W-1:0]  feature;
        logic [EST_W-1:0]   estimate;
    } entry_t;

    typedef struct packed {
        logic is_match;
        logic is_free;
        logic is_farther;
        logic is_stale;
        logic is_own;
    } verdict_t;

endpackage

// ===== hdl/nbt_req_if.sv =====
interface nbt_req_if import nbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   sender_id;
    logic [DIST_W-1:0] distance;
    logic [FEAT_W-1:0] sender_feature;
    logic [EST_W-1:0]  sender_estimate;

    modport source (
        output valid, action, now, sender_id, distance, sender_feature, sender_estimate,
        input  ready
    );

    modport sink (
        input  valid, action, now, sender_id, distance, sender_feature, sender_estimate,
        output ready
    );
endinterface

// ===== hdl/nbt_rsp_if.sv =====
interface nbt_rsp_if import nbt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic              was_new;
    logic [LIVE_W-1:0] live_count;

    modport source (
        output valid, accepted, slot, was_new, live_count,
        input  ready
    );

    modport sink (
        input  valid, accepted, slot, was_new, live_count,
        output ready
    );
endinterface

// ===== hdl/nbt_judge.sv =====
module nbt_judge import nbt_pkg::*;
(
    input  entry_t             entry,
    input  logic               live,
    input  logic [ID_W-1:0]    sender_id,
    input  logic [TIME_W-1:0]  now,
    input  logic [Q_W-1:0]     far_q,
    input  logic [TIME_W-1:0]  timeout_ticks,
    input  logic [OWN_W-1:0]   own_feature,
    output verdict_t           verdict
);
    logic [TIME_W-1:0] age;

    // modulo 2^32 age, so a wrapped clock still works
    assign age = now - entry.last_heard;

    always_comb
    begin
        verdict.is_match   = live && (entry.id == sender_id);
        verdict.is_free    = !live;
        verdict.is_farther = entry.dist_q > far_q;
        verdict.is_stale   = live && (age > timeout_ticks);
        verdict.is_own     = live && (entry.feature == FEAT_W'(own_feature));
    end
endmodule

// ===== hdl/nbt_blend.sv =====
module nbt_blend import nbt_pkg::*;
(
    input  logic              clk,
    input  logic              start,
    input  logic [Q_W-1:0]    old_q,
    input  logic [DIST_W-1:0] distance,
    output logic [Q_W-1:0]    blend_q
);
    logic [23:0]    old_term;
    logic [23:0]    new_term;
    logic [23:0]    sum;
    logic [Q_W-1:0] blend_reg;

    // old*230 + (d<<8)*26 + 128 stays below 2^24
    assign old_term = 24'(old_q) * 24'(AVG_OLD_WEIGHT);
    assign new_term = 24'({distance, 8'h00}) * 24'(AVG_NEW_WEIGHT);
    assign sum      = old_term + new_term + 24'd128;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            blend_reg <= sum[23:8];
        end
    end

    assign blend_q = blend_reg;
endmodule

// ===== hdl/neighbor_table_farthest_replace.sv =====
// channel | dir | handshake           | payload
// req     | in  | req.valid/req.ready | action, now, sender_id, distance, sender_feature,
//         |     |                     | sender_estimate
// rsp     | out | rsp.valid/rsp.ready | accepted, slot, was_new, live_count
// cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// a message item runs a search sweep, then a decide step, a blend step when it blends and a
// write step when it writes the table, then a prune sweep, and then its result is loaded;
// a time step runs only the prune sweep; the single read port of the entry memory sets
// this pace, one entry per cycle in the search sweep and again in the prune sweep.
// reset empties the table at once through per-slot valid bits, no clearing pass.
// req.ready is high only between items, the cycle after the result is loaded; a finished
// result waits in the rsp register while the next item is taken, and a stalled rsp
// holds the block only at its end.
`include "assert_macros.svh"

module neighbor_table_farthest_replace import nbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nbt_req_if.sink               req,
    nbt_rsp_if.source             rsp
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_BLEND  = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_PRUNE  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

    // configuration
    logic [TIME_W-1:0]   timeout_reg;
    logic [OWN_W-1:0]    own_reg;
    logic                average_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // sequencer
    logic [2:0]             state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   rd_live_reg;
    logic [ADDR_W-1:0]      rd_slot_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    // latched item
    logic              action_reg;
    logic [TIME_W-1:0] now_reg;
    logic [ID_W-1:0]   sender_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [FEAT_W-1:0] feature_reg;
    logic [EST_W-1:0]  estimate_reg;

    // search results
    logic               match_found_reg;
    logic [ADDR_W-1:0]  match_slot_reg;
    logic [Q_W-1:0]     match_dist_reg;
    logic [HEARD_W-1:0] match_heard_reg;
    logic               free_found_reg;
    logic [ADDR_W-1:0]  free_slot_reg;
    logic [Q_W-1:0]     far_q_reg;
    logic [ADDR_W-1:0]  far_slot_reg;

    logic              accept_reg;
    logic              fresh_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [CNT_W-1:0]  live_cnt_reg;

    // result register
    logic              rsp_valid_reg;
    logic              rsp_accepted_reg;
    logic [SLOT_W-1:0] rsp_slot_reg;
    logic              rsp_was_new_reg;
    logic [LIVE_W-1:0] rsp_live_reg;

    // entry memory
    entry_t            mem [TABLE_DEPTH];
    entry_t            rd_data_reg;
    entry_t            wr_entry;
    logic              mem_we;
    logic [ADDR_W-1:0] rd_addr;

    logic              req_fire;
    logic              sweeping;
    logic              rsp_load;
    logic              evict_ok;
    logic [Q_W-1:0]    blend_q;
    logic [HEARD_W-1:0] heard_next;
    verdict_t          verdict;

    assign req_fire = req.valid && req.ready;
    assign sweeping = (state_reg == S_FIND) || (state_reg == S_PRUNE);
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign rd_addr  = (cnt_reg < CNT_END) ? cnt_reg[ADDR_W-1:0] : '0;
    assign mem_we   = (state_reg == S_WRITE);

    // newcomer must be more than the margin closer than the farthest entry
    assign evict_ok = ({1'b0, dist_reg} + {1'b0, margin_reg}) < {1'b0, far_q_reg[Q_W-1:8]};

    assign req.ready = (state_reg == S_IDLE);

    nbt_judge u_judge (
        .entry         (rd_data_reg),
        .live          (valid_reg[rd_slot_reg]),
        .sender_id     (sender_reg),
        .now           (now_reg),
        .far_q         (far_q_reg),
        .timeout_ticks (timeout_reg),
        .own_feature   (own_reg),
        .verdict       (verdict)
    );

    nbt_blend u_blend (
        .clk      (clk),
        .start    (state_reg == S_BLEND),
        .old_q    (match_dist_reg),
        .distance (dist_reg),
        .blend_q  (blend_q)
    );

    always_comb
    begin
        heard_next = (match_heard_reg == HEARD_MAX) ? HEARD_MAX : match_heard_reg + 8'd1;
        wr_entry.id         = sender_reg;
        wr_entry.last_heard = now_reg;
        wr_entry.feature    = feature_reg;
        wr_entry.estimate   = estimate_reg;
        if (fresh_reg)
        begin
            wr_entry.dist_q = {dist_reg, 8'h00};
            wr_entry.heard  = '0;
        end
        else
        begin
            wr_entry.dist_q = average_reg ? blend_q : {dist_reg, 8'h00};
            wr_entry.heard  = heard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            own_reg         <= '0;
            average_reg     <= 1'b0;
            margin_reg      <= MARGIN_RESET;
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            rd_live_reg     <= 1'b0;
            valid_reg       <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            accept_reg      <= 1'b0;
            fresh_reg       <= 1'b0;
            live_cnt_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data[TIME_W-1:0];
                    CFG_OWN:     own_reg     <= cfg_data[OWN_W-1:0];
                    CFG_AVERAGE: average_reg <= cfg_data[0];
                    CFG_MARGIN:  margin_reg  <= cfg_data[MARGIN_W-1:0];
                    default:     ;
                endcase
            end

            // read data follows the address in the next cycle
            rd_live_reg <= sweeping && (cnt_reg < CNT_END);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        cnt_reg         <= '0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        accept_reg      <= 1'b0;
                        fresh_reg       <= 1'b0;
                        live_cnt_reg    <= '0;
                        state_reg <= (req.action && (req.sender_id != '0)) ? S_FIND : S_PRUNE;
                    end
                end
                S_FIND:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (rd_live_reg)
                    begin
                        if (verdict.is_match)
                        begin
                            match_found_reg <= 1'b1;
                        end
                        if (verdict.is_free)
                        begin
                            free_found_reg <= 1'b1;
                        end
                    end
                    if (cnt_reg == CNT_END)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg <= '0;
                    if (match_found_reg)
                    begin
                        accept_reg <= 1'b1;
                        fresh_reg  <= 1'b0;
                        state_reg  <= average_reg ? S_BLEND : S_WRITE;
                    end
                    else if (free_found_reg || evict_ok)
                    begin
                        accept_reg <= 1'b1;
                        fresh_reg  <= 1'b1;
                        state_reg  <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_PRUNE;
                    end
                end
                S_BLEND:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    cnt_reg             <= '0;
                    state_reg           <= S_PRUNE;
                end
                S_PRUNE:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (rd_live_reg)
                    begin
                        if (verdict.is_stale)
                        begin
                            valid_reg[rd_slot_reg] <= 1'b0;
                        end
                        else if (verdict.is_own)
                        begin
                            live_cnt_reg <= live_cnt_reg + CNT_W'(1);
                        end
                    end
                    if (cnt_reg == CNT_END)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_addr;

        if (req_fire)
        begin
            action_reg   <= req.action;
            now_reg      <= req.now;
            sender_reg   <= req.sender_id;
            dist_reg     <= req.distance;
            feature_reg  <= req.sender_feature;
            estimate_reg <= req.sender_estimate;
            far_q_reg    <= '0;
            far_slot_reg <= '0;
        end

        if ((state_reg == S_FIND) && rd_live_reg)
        begin
            // first match and first free slot win, farthest keeps the earliest on ties
            if (verdict.is_match && !match_found_reg)
            begin
                match_slot_reg  <= rd_slot_reg;
                match_dist_reg  <= rd_data_reg.dist_q;
                match_heard_reg <= rd_data_reg.heard;
            end
            if (verdict.is_free && !free_found_reg)
            begin
                free_slot_reg <= rd_slot_reg;
            end
            if (verdict.is_farther)
            begin
                far_q_reg    <= rd_data_reg.dist_q;
                far_slot_reg <= rd_slot_reg;
            end
        end

        if (state_reg == S_DECIDE)
        begin
            if (match_found_reg)
            begin
                slot_reg <= match_slot_reg;
            end
            else if (free_found_reg)
            begin
                slot_reg <= free_slot_reg;
            end
            else if (evict_ok)
            begin
                slot_reg <= far_slot_reg;
            end
            else
            begin
                slot_reg <= '0;
            end
        end

        if (rsp_load)
        begin
            rsp_accepted_reg <= action_reg && accept_reg;
            rsp_slot_reg     <= accept_reg ? SLOT_W'(slot_reg) : '0;
            rsp_was_new_reg  <= accept_reg && fresh_reg;
            rsp_live_reg     <= LIVE_W'(live_cnt_reg);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.accepted   = rsp_accepted_reg;
    assign rsp.slot       = rsp_slot_reg;
    assign rsp.was_new    = rsp_was_new_reg;
    assign rsp.live_count = rsp_live_reg;

    `ASSERT_NOW(a_reject_clean, rsp_valid_reg && !rsp_accepted_reg, (rsp_slot_reg == '0) && !rsp_was_new_reg)
    `ASSERT_NEXT(a_write_marks_valid, state_reg == S_WRITE, valid_reg[slot_reg])
    `ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_reg != S_IDLE)
    `ASSERT_NOW(a_live_bound, state_reg == S_DONE, live_cnt_reg <= CNT_END)
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import nbt_pkg::*;
();

    localparam int N_DIRECTED    = 18;
    localparam int ID_POOL       = 80;
    localparam int STALL_AFTER   = 400;
    localparam int STALL_CYCLES  = 1500;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 300;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    typedef struct packed {
        logic               action;
        logic [TIME_W-1:0]  now;
        logic [ID_W-1:0]    sender_id;
        logic [DIST_W-1:0]  distance;
        logic [FEAT_W-1:0]  sender_feature;
        logic [EST_W-1:0]   sender_estimate;
    } nbt_msg_t;

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic              was_new;
        logic [LIVE_W-1:0] live_count;
    } nbt_report_t;

    typedef struct packed {
        logic        typed;
        nbt_msg_t    msg;
        nbt_report_t report;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nbt_req_if req();
    nbt_rsp_if rsp();

    neighbor_table_farthest_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // shadow of the neighbor table and its registers
    entry_t              neighbors [TABLE_DEPTH];
    logic [TIME_W-1:0]   silence_limit = TIMEOUT_RESET;
    logic [OWN_W-1:0]    home_feature  = '0;
    logic                blend_on      = 1'b0;
    logic [MARGIN_W-1:0] evict_margin  = MARGIN_RESET;

    nbt_report_t       pending_reports [$];
    int                mismatch_count = 0;
    int                items_sent     = 0;
    int                reports_seen   = 0;
    logic [TIME_W-1:0] sim_now;
    logic [ID_W-1:0]   id_base;
    int unsigned       step_span;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            neighbors[i] = '0;
    end

    function automatic nbt_report_t update_neighbors(input nbt_msg_t m);
        nbt_report_t       r;
        int                i;
        int                slot;
        int                far_slot;
        logic              hit;
        logic              fresh;
        logic [Q_W-1:0]    far_q;
        logic [TIME_W-1:0] age;
        int unsigned       mixed;
        int unsigned       live;
        r = '0;
        slot = 0;
        hit = 1'b0;
        fresh = 1'b0;
        live = 0;
        if (m.action && m.sender_id != '0) begin
            for (i = 0; i < TABLE_DEPTH; i++)
                if (!hit && neighbors[i].id == m.sender_id) begin
                    hit = 1'b1;
                    slot = i;
                end
            for (i = 0; i < TABLE_DEPTH; i++)
                if (!hit && neighbors[i].id == '0) begin
                    hit = 1'b1;
                    fresh = 1'b1;
                    slot = i;
                end
            if (!hit) begin
                // table full: farthest entry, earliest slot on ties
                far_q = '0;
                far_slot = 0;
                for (i = 0; i < TABLE_DEPTH; i++)
                    if (neighbors[i].dist_q > far_q) begin
                        far_q = neighbors[i].dist_q;
                        far_slot = i;
                    end
                if (int'(m.distance) + int'(evict_margin) < int'(far_q[Q_W-1:8])) begin
                    hit = 1'b1;
                    fresh = 1'b1;
                    slot = far_slot;
                end
            end
            if (hit) begin
                neighbors[slot].last_heard = m.now;
                if (fresh) begin
                    neighbors[slot].id = m.sender_id;
                    neighbors[slot].dist_q = {m.distance, 8'h00};
                    neighbors[slot].heard = '0;
                end else begin
                    if (blend_on) begin
                        mixed = 32'(neighbors[slot].dist_q) * 32'(AVG_OLD_WEIGHT)
                              + (32'(m.distance) << 8) * 32'(AVG_NEW_WEIGHT) + 32'd128;
                        neighbors[slot].dist_q = mixed[23:8];
                    end else begin
                        neighbors[slot].dist_q = {m.distance, 8'h00};
                    end
                    if (neighbors[slot].heard != HEARD_MAX)
                        neighbors[slot].heard = neighbors[slot].heard + HEARD_W'(1);
                end
                neighbors[slot].feature = m.sender_feature;
                neighbors[slot].estimate = m.sender_estimate;
                r.accepted = 1'b1;
                r.slot = SLOT_W'(slot);
                r.was_new = fresh;
            end
        end
        for (i = 0; i < TABLE_DEPTH; i++) begin
            age = m.now - neighbors[i].last_heard;
            if (neighbors[i].id != '0 && age > silence_limit)
                neighbors[i].id = '0;
        end
        for (i = 0; i < TABLE_DEPTH; i++)
            if (neighbors[i].id != '0 && neighbors[i].feature == FEAT_W'(home_feature))
                live++;
        r.live_count = LIVE_W'(live);
        return r;
    endfunction

    function automatic directed_row_t row(input logic typed, input logic act,
                                          input logic [TIME_W-1:0] now,
                                          input logic [ID_W-1:0] id,
                                          input logic [DIST_W-1:0] dist_in,
                                          input logic [FEAT_W-1:0] feat,
                                          input logic [EST_W-1:0] est,
                                          input logic acc, input int slot,
                                          input logic fresh, input int live);
        directed_row_t d;
        d.typed = typed;
        d.msg = '{act, now, id, dist_in, feat, est};
        d.report = '{acc, SLOT_W'(slot), fresh, LIVE_W'(live)};
        return d;
    endfunction

    function automatic nbt_msg_t draw_message();
        nbt_msg_t    m;
        int unsigned pick;
        pick = $urandom_range(0, 63);
        if (pick == 0)
            sim_now = $urandom();
        else if (pick < 4)
            sim_now = sim_now + $urandom_range(0, 200000);
        else
            sim_now = sim_now + $urandom_range(0, step_span);
        m.now = sim_now;
        m.action = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 31);
        if (pick == 0)
            m.sender_id = '0;
        else if (pick == 1)
            m.sender_id = ID_W'($urandom_range(0, 65535));
        else
            m.sender_id = id_base + ID_W'($urandom_range(0, ID_POOL - 1));
        // far distances often, so ties and evictions happen
        if ($urandom_range(0, 3) == 0)
            m.distance = DIST_W'($urandom_range(248, 255));
        else
            m.distance = DIST_W'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            m.sender_feature = FEAT_W'($urandom_range(0, 255));
        else
            m.sender_feature = FEAT_W'($urandom_range(0, 3));
        m.sender_estimate = EST_W'($urandom_range(0, 255));
        return m;
    endfunction

    task automatic send_message(input nbt_msg_t m, input logic typed,
                                input nbt_report_t typed_report);
        int          gap;
        nbt_report_t predicted;
        gap = ((items_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.action          <= m.action;
        req.now             <= m.now;
        req.sender_id       <= m.sender_id;
        req.distance        <= m.distance;
        req.sender_feature  <= m.sender_feature;
        req.sender_estimate <= m.sender_estimate;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        predicted = update_neighbors(m);
        pending_reports.push_back(typed ? typed_report : predicted);
        items_sent++;
    endtask

    task automatic wait_all_reports();
        req.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // narrow registers get junk in the unused upper bits
    task automatic program_regs(input logic [TIME_W-1:0] tmo, input logic [OWN_W-1:0] own,
                                input logic blend, input logic [MARGIN_W-1:0] margin);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_OWN, ($urandom() & ~32'h3) | 32'(own));
        write_reg(CFG_AVERAGE, ($urandom() & ~32'h1) | 32'(blend));
        write_reg(CFG_MARGIN, ($urandom() & ~32'hFF) | 32'(margin));
        cfg_we <= 1'b0;
        silence_limit = tmo;
        home_feature  = own;
        blend_on      = blend;
        evict_margin  = margin;
    endtask

    task automatic run_random(input int count, input int unsigned span);
        id_base = ID_W'($urandom_range(1, 65535 - ID_POOL));
        sim_now = $urandom();
        step_span = span;
        repeat (count) send_message(draw_message(), 1'b0, '0);
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result side
    initial begin
        int          gap;
        logic        hold_done;
        nbt_report_t want;
        nbt_report_t got;
        hold_done = 1'b0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!hold_done && reports_seen == STALL_AFTER) begin
                // long hold-off so the block backs up into its input
                gap = STALL_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = ((reports_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 5);
            end
            if (gap > 0) begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
            got = '{rsp.accepted, rsp.slot, rsp.was_new, rsp.live_count};
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected item, expected none actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("slot", want.slot, got.slot);
                check_field("was_new", want.was_new, got.was_new);
                check_field("live_count", want.live_count, got.live_count);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("neighbor_table_farthest_replace regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        directed_row_t rows [N_DIRECTED];
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_TIMEOUT;
        cfg_data            <= '0;
        req.valid           <= 1'b0;
        req.action          <= 1'b0;
        req.now             <= '0;
        req.sender_id       <= '0;
        req.distance        <= '0;
        req.sender_feature  <= '0;
        req.sender_estimate <= '0;
        rows = '{
            // empty table, prune only
            row(1, 0, 32'd0, 16'h0000, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0),
            // sender id zero is dropped
            row(1, 1, 32'd0, 16'h0000, 8'd255, 8'd0, 8'd255, 0, 0, 0, 0),
            row(1, 1, 32'd0, 16'hFFFF, 8'd255, 8'd0, 8'd255, 1, 0, 1, 1),
            // same sender again, now on a foreign feature
            row(1, 1, 32'd1, 16'hFFFF, 8'd0, 8'hFF, 8'd0, 1, 0, 0, 0),
            row(1, 1, 32'd2, 16'h0001, 8'd10, 8'd0, 8'd7, 1, 1, 1, 1),
            // prune only, message fields ignored
            row(1, 0, 32'd2, 16'h1234, 8'd3, 8'd0, 8'd0, 0, 0, 0, 1),
            // one tick past the timeout clears, exactly at it keeps
            row(1, 0, 32'd65537, 16'h0000, 8'd0, 8'd0, 8'd0, 0, 0, 0, 1),
            row(1, 0, 32'd65538, 16'h0000, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0),
            row(1, 1, 32'hFFFF_FFFF, 16'h0002, 8'd128, 8'd0, 8'd1, 1, 0, 1, 1),
            // time wraps, entry stays young
            row(1, 0, 32'd5, 16'h0000, 8'd0, 8'd0, 8'd0, 0, 0, 0, 1),
            row(0, 1, 32'd6, 16'h0003, 8'd20, 8'd3, 8'd2, 0, 0, 0, 0),
            row(0, 1, 32'd7, 16'h0002, 8'd40, 8'd0, 8'd3, 0, 0, 0, 0),
            row(0, 1, 32'd8, 16'h8000, 8'd1, 8'h80, 8'h80, 0, 0, 0, 0),
            row(0, 1, 32'd8, 16'h5555, 8'h55, 8'h55, 8'hAA, 0, 0, 0, 0),
            row(0, 1, 32'd9, 16'hAAAA, 8'hAA, 8'd2, 8'h55, 0, 0, 0, 0),
            row(0, 1, 32'd9, 16'h5555, 8'hAA, 8'd0, 8'h55, 0, 0, 0, 0),
            row(1, 0, 32'h7FFF_FFFF, 16'h0000, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0),
            row(1, 0, 32'h8000_0000, 16'h0000, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0)
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_message(rows[k].msg, rows[k].typed, rows[k].report);

        // reset settings, moderate timeouts
        run_random(200, 2000);
        wait_all_reports();

        // nothing times out, table fills, any closer newcomer evicts
        program_regs(32'hFFFF_FFFF, 2'd3, 1'b1, 8'd0);
        run_random(250, 50);
        wait_all_reports();

        // zero timeout keeps only entries heard this tick, no eviction possible
        program_regs(32'd0, 2'd1, 1'b0, 8'd255);
        run_random(200, 1);
        wait_all_reports();

        program_regs(TIME_W'($urandom_range(200, 3000)), 2'd2, 1'b1,
                     MARGIN_W'($urandom_range(0, 40)));
        run_random(300, 20);
        wait_all_reports();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("neighbor_table_farthest_replace regression: pass");
        else
            $display("neighbor_table_farthest_replace regression: fail");
        $finish;
    end

endmodule
